[sv/cpsg_pkg.sv]
// Shared types, constants and the cosine table generator for the channel peak share gate.
`default_nettype none

package cpsg_pkg;

	localparam int MAX_CHANNELS_DEF   = 256;
	localparam int COS_TABLE_BITS_DEF = 10;

	// Queue depth between front and back; a power of two so pointers wrap naturally.
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [16:0] UNIT_Q16   = 17'h10000;
	localparam logic [23:0] TOTAL_MAX  = 24'hFFFFFF;
	localparam logic [63:0] Q30_ONE    = 64'h4000_0000;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	localparam logic [7:0] TAYLOR_DIVS [6] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

	// Configuration register indexes.
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_SOURCE = 2'd1;
	localparam logic [1:0] REG_VIS    = 2'd2;

	typedef struct packed {
		logic        mode;
		logic [15:0] source_level;
		logic [16:0] visibility;
	} cfg_t;

	// One entry of the front-to-back queue: the channel level and the set
	// summary as it stands after this channel.
	typedef struct packed {
		logic        last;
		logic [15:0] level;
		logic [23:0] total;
		logic [15:0] peak;
		logic [7:0]  peak_idx;
		logic        err;
	} qent_t;

	typedef struct packed {
		logic valid;
		logic full;
	} qstat_t;

	typedef enum logic {
		BK_IDLE,
		BK_DIV
	} bk_state_t;

	// cos(pi/2 * t) for t in Q16 (0..65536), result Q16 clamped to 0..65536.
	// Evaluated at elaboration only, to fill the quarter-wave table.
	function automatic logic [16:0] quarter_cos(input logic [16:0] t);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        p;
		logic [63:0]        r;
		logic signed [63:0] b;
		x  = (64'(t) * HALF_PI_Q30) >> 16;
		x2 = (x * x) >> 30;
		b  = $signed(Q30_ONE);
		for (int i = 0; i < 6; i++) begin
			p = (x2 * 64'(b)) >> 30;
			b = $signed(Q30_ONE) - $signed(p / 64'(TAYLOR_DIVS[i]));
			if (b < 0) b = 0;
		end
		r = (64'(b) + 64'd8192) >> 14;
		if (r > 64'(UNIT_Q16)) r = 64'(UNIT_Q16);
		return 17'(r);
	endfunction

endpackage

`default_nettype wire

[sv/cpsg_front.sv]
// Front end: accepts samples, turns them into channel levels and keeps the set summary.
`default_nettype none

module cpsg_front import cpsg_pkg::*; #(
	parameter int MAX_CHANNELS   = MAX_CHANNELS_DEF,
	parameter int COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [23:0] s_tdata,
	input  wire logic        s_tlast,
	input  wire logic        pop,
	output      logic        push,
	output      qent_t       push_data
);

	localparam int NQ    = 1 << (COS_TABLE_BITS - 2);
	localparam int IDX_W = COS_TABLE_BITS - 1;
	localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

	// Quarter-wave table, one entry past the quadrant so that folding reaches t = one.
	logic [16:0] cos_rom [NQ + 1];
	for (genvar j = 0; j <= NQ; j++) begin : g_rom
		assign cos_rom[j] = quarter_cos(17'(j << (18 - COS_TABLE_BITS)));
	end

	logic [QCNT_W-1:0] inflight_q;
	logic              accept;

	assign s_tready = (inflight_q < QCNT_W'(QDEPTH));
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + QCNT_W'(accept) - QCNT_W'(pop);
		end
	end

	// Stage 1: table lookup with quadrant folding.
	logic [1:0]          quad;
	logic [COS_TABLE_BITS-3:0] qj;
	logic [IDX_W-1:0]    tidx;
	logic [16:0]         tent;
	logic signed [17:0]  cval;

	assign quad = s_tdata[15:14];
	assign qj   = s_tdata[13:16-COS_TABLE_BITS];
	assign tidx = quad[0] ? (IDX_W'(NQ) - IDX_W'(qj)) : IDX_W'(qj);
	assign tent = cos_rom[tidx];
	assign cval = (quad == 2'd1 || quad == 2'd2) ? -$signed({1'b0, tent}) : $signed({1'b0, tent});

	logic               valid_s1, last_s1, mode_s1, neg_s1;
	logic [15:0]        raw_s1;
	logic signed [17:0] c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= s_tlast;
		mode_s1 <= cfg.mode;
		neg_s1  <= !cfg.mode && s_tdata[16];
		raw_s1  <= s_tdata[16] ? 16'd0 : s_tdata[15:0];
		c_s1    <= cval;
	end

	// Stage 2: fringe factor 2^32 + V*c.
	logic [16:0]        vsat;
	logic signed [35:0] prod;
	logic signed [35:0] fsum;

	assign vsat = (cfg.visibility > UNIT_Q16) ? UNIT_Q16 : cfg.visibility;
	assign prod = 36'($signed({1'b0, vsat}) * c_s1);
	assign fsum = 36'sh1_0000_0000 + prod;

	logic        valid_s2, last_s2, mode_s2, neg_s2;
	logic [15:0] raw_s2;
	logic [33:0] f_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		last_s2 <= last_s1;
		mode_s2 <= mode_s1;
		neg_s2  <= neg_s1;
		raw_s2  <= raw_s1;
		f_s2    <= (fsum < 0) ? 34'd0 : 34'(fsum);
	end

	// Stage 3: scale by the source level and round.
	logic [49:0] sprod;
	logic [16:0] rlev;

	assign sprod = 50'(cfg.source_level) * 50'(f_s2);
	assign rlev  = 17'((sprod + 50'h1_0000_0000) >> 33);

	logic        valid_s3, last_s3, neg_s3;
	logic [15:0] level_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		last_s3  <= last_s2;
		neg_s3   <= neg_s2;
		level_s3 <= !mode_s2 ? raw_s2 : (rlev[16] ? 16'hFFFF : rlev[15:0]);
	end

	// Set summary.
	logic [23:0]      total_q, total_n;
	logic [15:0]      peak_q, peak_n;
	logic [7:0]       pidx_q, pidx_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic             err_q, err_n;
	logic [24:0]      tsum;

	assign tsum = 25'(total_q) + 25'(level_s3);

	always_comb begin
		total_n = total_q;
		peak_n  = peak_q;
		pidx_n  = pidx_q;
		count_n = count_q;
		err_n   = err_q;
		if (count_q < CNT_W'(MAX_CHANNELS)) begin
			if (neg_s3) begin
				err_n = 1'b1;
			end else begin
				total_n = tsum[24] ? TOTAL_MAX : tsum[23:0];
				if (level_s3 > peak_q) begin
					peak_n = level_s3;
					pidx_n = 8'(count_q);
				end
			end
			count_n = count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			peak_q  <= '0;
			pidx_q  <= '0;
			count_q <= '0;
			err_q   <= 1'b0;
		end else if (valid_s3) begin
			if (last_s3) begin
				total_q <= '0;
				peak_q  <= '0;
				pidx_q  <= '0;
				count_q <= '0;
				err_q   <= 1'b0;
			end else begin
				total_q <= total_n;
				peak_q  <= peak_n;
				pidx_q  <= pidx_n;
				count_q <= count_n;
				err_q   <= err_n;
			end
		end
	end

	assign push               = valid_s3;
	assign push_data.last     = last_s3;
	assign push_data.level    = level_s3;
	assign push_data.total    = total_n;
	assign push_data.peak     = peak_n;
	assign push_data.peak_idx = pidx_n;
	assign push_data.err      = err_n;

endmodule

`default_nettype wire

[sv/cpsg_queue.sv]
// Short FIFO between the front end and the back end.
`default_nettype none

module cpsg_queue import cpsg_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire qent_t push_data,
	input  wire logic  pop,
	output      qstat_t stat,
	output      qent_t pop_data
);

	qent_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QPTR_W'(1);
			if (pop)  rd_q <= rd_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	assign stat.valid = (cnt_q != '0);
	assign stat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign pop_data   = mem_q[rd_q];

endmodule

`default_nettype wire

[sv/cpsg_back.sv]
// Back end: finishes each result, dividing peak by total at the end of a set with no error and a nonzero total.
`default_nettype none

module cpsg_back import cpsg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire qstat_t      qstat,
	input  wire qent_t       qdata,
	output      logic        pop,
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [87:0] m_tdata,
	output      logic        m_tlast
);

	bk_state_t   st_q, st_n;
	qent_t       ent_q;
	logic [23:0] rem_q;
	logic [16:0] num_q;
	logic [16:0] quo_q;
	logic [4:0]  bit_q;

	logic        ov_q;
	logic        out_free;
	logic        needs_div;
	logic        load_div, load_direct, div_done;

	assign out_free  = !ov_q || m_tready;
	assign needs_div = qdata.last && !qdata.err && (qdata.total != '0);

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			BK_IDLE: if (qstat.valid && out_free && needs_div) st_n = BK_DIV;
			BK_DIV:  if (bit_q == 5'd0) st_n = BK_IDLE;
			default: st_n = BK_IDLE;
		endcase
	end

	always_comb begin
		pop         = 1'b0;
		load_div    = 1'b0;
		load_direct = 1'b0;
		div_done    = 1'b0;
		unique case (st_q)
			BK_IDLE: begin
				pop         = qstat.valid && out_free;
				load_div    = pop && needs_div;
				load_direct = pop && !needs_div;
			end
			BK_DIV:  div_done = (bit_q == 5'd0);
			default: ;
		endcase
	end

	// One quotient bit a cycle; the remainder starts at the top 16 numerator bits
	// because the quotient never exceeds 17 bits.
	logic [32:0] numer;
	logic [24:0] rem_sh;
	logic        ge;
	logic [16:0] quo_n;
	logic [16:0] unc_div;

	assign numer   = {1'b0, qdata.peak, 16'd0} + 33'(qdata.total >> 1);
	assign rem_sh  = {rem_q, num_q[bit_q]};
	assign ge      = rem_sh >= {1'b0, ent_q.total};
	assign quo_n   = {quo_q[15:0], ge};
	assign unc_div = quo_n[16] ? 17'd0 : UNIT_Q16 - quo_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if (load_direct || div_done) ov_q <= 1'b1;
			else if (m_tready)           ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_div) begin
			ent_q <= qdata;
			rem_q <= 24'(numer[32:17]);
			num_q <= numer[16:0];
			quo_q <= '0;
			bit_q <= 5'd16;
		end else if (st_q == BK_DIV) begin
			rem_q <= ge ? 24'(rem_sh - {1'b0, ent_q.total}) : rem_sh[23:0];
			quo_q <= quo_n;
			bit_q <= bit_q - 5'd1;
		end
		if (load_direct) begin
			m_tlast <= qdata.last;
			m_tdata <= {6'd0,
				qdata.last ? qdata.err      : 1'b0,
				qdata.last ? qdata.peak_idx : 8'd0,
				qdata.last ? qdata.peak     : 16'd0,
				qdata.last ? qdata.total    : 24'd0,
				qdata.last ? UNIT_Q16       : 17'd0,
				qdata.level};
		end else if (div_done) begin
			m_tlast <= 1'b1;
			m_tdata <= {6'd0, ent_q.err, ent_q.peak_idx, ent_q.peak, ent_q.total,
				unc_div, ent_q.level};
		end
	end

	assign m_tvalid = ov_q;

endmodule

`default_nettype wire

[sv/channel_peak_share_gate.sv]
// Top level of the channel peak share gate: configuration, front end, queue and back end.
`default_nettype none

// Channel  Direction  Payload
// s_*      in         tdata[16:0] sample_value, tlast = last of set
// m_*      out        tdata: level, uncertainty, total, peak, index, status; tlast = done_res
// cfg_*    in         write enable, index, 17-bit data; no read-back
//
// A sample passes a table lookup, the visibility product, the source product and the
// set summary update, then the queue and the back end's output register, before its
// result waits on m_*. The front end holds at most four samples between their transfer
// and their removal from the queue, so s_tready falls while four are in flight.
// The last sample of a set with no error and a nonzero total holds the back end in the
// bit-serial divider until all 17 quotient bits are done.
// Reset clears the pipeline valid bits, the queue, the summary and the registers to
// their reset values; a stalled output stalls the front once four samples are in flight.

module channel_peak_share_gate import cpsg_pkg::*; #(
	parameter int MAX_CHANNELS   = MAX_CHANNELS_DEF,
	parameter int COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [16:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [23:0] s_tdata,   // [16:0] sample_value
	input  wire logic        s_tlast,
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [87:0] m_tdata,   // [15:0] channel_level, [32:16] uncertainty,
	                                    // [56:33] total_level, [72:57] peak_level,
	                                    // [80:73] peak_index, [81] status
	output      logic        m_tlast    // done_res
);

	cfg_t cfg_q;

	// Registers are to be written only while the block is idle (the block itself does not
	// enforce this), so the pipeline may read them live.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= 1'b0;
			cfg_q.source_level <= 16'hFFFF;
			cfg_q.visibility   <= UNIT_Q16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:   cfg_q.mode         <= cfg_wdata[0];
				REG_SOURCE: cfg_q.source_level <= cfg_wdata[15:0];
				REG_VIS:    cfg_q.visibility   <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	logic   push, pop;
	qent_t  push_data, pop_data;
	qstat_t qstat;

	cpsg_front #(
		.MAX_CHANNELS  (MAX_CHANNELS),
		.COS_TABLE_BITS(COS_TABLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.pop      (pop),
		.push     (push),
		.push_data(push_data)
	);

	cpsg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.stat     (qstat),
		.pop_data (pop_data)
	);

	cpsg_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.qstat   (qstat),
		.qdata   (pop_data),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	// The credit count in the front end must never let the queue overflow.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!qstat.full || pop))
		else $error("queue written while full");

	// Results inside a set carry no summary.
	a_mid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[81:16] == '0))
		else $error("summary fields set before the end of a set");

	// Status, set by a negative sample in raw mode, forces uncertainty to one.
	a_err_unc: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast && m_tdata[81]) |-> (m_tdata[32:16] == UNIT_Q16))
		else $error("status set without full uncertainty");

	a_unc_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[32:16] <= UNIT_Q16))
		else $error("uncertainty above one");

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the channel peak share gate: stream stimulus, scoreboard, summary.
`default_nettype none

module tb;
	import cpsg_pkg::*;

	localparam int NUM_RANDOM = 1750;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_CH = 256;

	// One pending input transfer: the sample, its last mark and a pre-drawn idle gap.
	typedef struct packed {
		logic [16:0] sample;
		logic        last;
		logic [3:0]  gap;
	} sample_item_t;

	// One expected output transfer, split into the fields of m_tdata plus done_res.
	typedef struct packed {
		logic [15:0] level;
		logic        done;
		logic [16:0] unc;
		logic [23:0] total;
		logic [15:0] peak;
		logic [7:0]  idx;
		logic        status;
	} level_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_MODE;
	logic [16:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic        m_tlast;

	channel_peak_share_gate i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor copy of the configuration registers and the per-set accumulators.
	logic        p_mode;
	logic [15:0] p_source;
	logic [16:0] p_vis;
	logic [23:0] p_total;
	logic [15:0] p_peak;
	logic [7:0]  p_peak_idx;
	int unsigned p_count;
	logic        p_error;

	sample_item_t  pending_samples[$];
	level_result_t expected_levels[$];
	logic [17:0]   cos_lut[1 << 10];

	int unsigned cycle_count = 0;
	int unsigned mismatches = 0;
	int unsigned sets_done = 0;
	int unsigned levels_seen = 0;
	int unsigned error_sets = 0;
	int          out_wait = 0;

	// Quarter-wave cosine by a truncating Taylor series in Q30, written afresh for the predictor.
	function automatic logic [16:0] cos_quarter(input longint unsigned t);
		longint unsigned x, x2, p, r;
		longint          b;
		int unsigned     dv[6];
		dv = '{132, 90, 56, 30, 12, 2};
		x  = (t * 64'd1686629713) >> 16;
		x2 = (x * x) >> 30;
		b  = 64'sd1 << 30;
		for (int i = 0; i < 6; i++) begin
			p = (x2 * longint'(b)) >> 30;
			b = (64'sd1 << 30) - longint'(p / dv[i]);
			if (b < 0)
				b = 0;
		end
		r = (longint'(b) + 8192) >> 14;
		if (r > 65536)
			r = 65536;
		return r[16:0];
	endfunction

	// Signed cosine for one 10-bit table slot, folded from the four quadrants.
	function automatic longint cos_slot(input int unsigned slot);
		int unsigned ph, quad, frac;
		ph   = slot << 6;
		quad = (ph >> 14) & 3;
		frac = (ph & 16'h3FFF) << 2;
		case (quad)
			0: return longint'(cos_quarter(frac));
			1: return -longint'(cos_quarter(65536 - frac));
			2: return -longint'(cos_quarter(frac));
			default: return longint'(cos_quarter(65536 - frac));
		endcase
	endfunction

	// Works out the output transfer one accepted sample causes and advances the set state.
	function automatic level_result_t predict_level(input logic [16:0] sample, input logic last);
		level_result_t   res;
		logic            neg;
		logic [15:0]     lvl;
		longint          vis, fr;
		longint unsigned r, q;
		int unsigned     sum;
		res = '0;
		neg = 1'b0;
		if (!p_mode) begin
			neg = sample[16];
			lvl = neg ? 16'd0 : sample[15:0];
		end else begin
			vis = (p_vis > 17'd65536) ? 65536 : longint'(p_vis);
			fr  = (64'sd1 << 32) + vis * longint'($signed(cos_lut[sample[15:6]]));
			if (fr < 0)
				fr = 0;
			r = (longint'(p_source) * fr + (64'd1 << 32)) >> 33;
			lvl = (r > 65535) ? 16'hFFFF : r[15:0];
		end
		if (p_count < MAX_CH) begin
			if (neg) begin
				p_error = 1'b1;
			end else begin
				sum = p_total + lvl;
				p_total = (sum > 24'hFFFFFF) ? 24'hFFFFFF : sum[23:0];
				if (lvl > p_peak) begin
					p_peak = lvl;
					p_peak_idx = p_count[7:0];
				end
			end
			p_count++;
		end
		res.level = lvl;
		if (last) begin
			res.done = 1'b1;
			if (p_error || p_total == 0) begin
				res.unc = 17'd65536;
			end else begin
				q = ((longint'(p_peak) << 16) + (p_total >> 1)) / p_total;
				res.unc = (q >= 65536) ? 17'd0 : 17'(65536 - q);
			end
			res.total = p_total;
			res.peak = p_peak;
			res.idx = p_peak_idx;
			res.status = p_error;
			p_total = '0;
			p_peak = '0;
			p_peak_idx = '0;
			p_count = 0;
			p_error = 1'b0;
		end
		return res;
	endfunction

	// Driver: takes the next pending sample, waits its gap, then holds tvalid until accepted.
	int drv_gap = 0;
	bit drv_loaded = 1'b0;
	sample_item_t drv_item;
	bit drv_accepted = 1'b0;
	bit m_accepted = 1'b0;

	// Handshakes are taken at the rising edge, where the transfers really happen.
	always @(posedge clk) begin
		drv_accepted <= s_tvalid && s_tready;
		m_accepted <= m_tvalid && m_tready;
	end

	always @(negedge clk) begin
		if (drv_accepted) begin
			// The transfer completed at the last rising edge.
			expected_levels.push_back(predict_level(drv_item.sample, drv_item.last));
			drv_loaded = 1'b0;
		end
		if (!drv_loaded && pending_samples.size() > 0) begin
			drv_item = pending_samples.pop_front();
			drv_gap = drv_item.gap;
			drv_loaded = 1'b1;
		end
		if (drv_loaded && drv_gap > 0) begin
			drv_gap--;
			s_tvalid <= 1'b0;
		end else if (drv_loaded) begin
			s_tvalid <= 1'b1;
			s_tdata <= {7'd0, drv_item.sample};
			s_tlast <= drv_item.last;
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// Receiver back-pressure: tready drops for a random number of cycles after each transfer.
	always @(negedge clk) begin
		if (m_accepted)
			out_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
		if (out_wait > 0) begin
			out_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Monitor: compares every accepted output transfer with the oldest expectation.
	always @(posedge clk) begin
		level_result_t want, got;
		cycle_count <= cycle_count + 1;
		if (m_tvalid && m_tready) begin
			got.level  = m_tdata[15:0];
			got.done   = m_tlast;
			got.unc    = m_tdata[32:16];
			got.total  = m_tdata[56:33];
			got.peak   = m_tdata[72:57];
			got.idx    = m_tdata[80:73];
			got.status = m_tdata[81];
			levels_seen++;
			if (got.done)
				sets_done++;
			if (got.done && got.status)
				error_sets++;
			if (expected_levels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output transfer: %h", got);
			end else begin
				want = expected_levels.pop_front();
				if (want !== got) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: level %h/%h done %b/%b unc %h/%h",
							" total %h/%h peak %h/%h idx %h/%h st %b/%b"},
							want.level, got.level, want.done, got.done, want.unc, got.unc,
							want.total, got.total, want.peak, got.peak, want.idx, got.idx,
							want.status, got.status);
				end
			end
		end
	end

	// Waits until the driver has no work left and every expected result has arrived.
	task automatic drain_all();
		while (pending_samples.size() > 0 || drv_loaded || s_tvalid || expected_levels.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Writes one configuration register at a falling edge, mirroring it in the predictor.
	task automatic write_reg(input logic [1:0] index, input logic [16:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (index)
			REG_MODE:   p_mode = value[0];
			REG_SOURCE: p_source = value[15:0];
			REG_VIS:    p_vis = value;
			default: ;
		endcase
	endtask

	task automatic queue_sample(input logic [16:0] sample, input logic last, input bit busy);
		sample_item_t it;
		it.sample = sample;
		it.last = last;
		it.gap = busy ? 4'd0 : 4'($urandom_range(0, 10));
		pending_samples.push_back(it);
	endtask

	// Queues one set of random channels; lengths stay short, a few exceed the channel bound.
	task automatic queue_set(input int len, input bit allow_neg, input bit busy);
		logic [16:0] s;
		for (int i = 0; i < len; i++) begin
			s = 17'($urandom());
			if (!allow_neg || $urandom_range(0, 15) != 0)
				s[16] = 1'b0;
			if ($urandom_range(0, 7) == 0)
				s[15:0] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			queue_sample(s, i == len - 1, busy);
		end
	endtask

	initial begin
		int sent;
		int len;
		for (int k = 0; k < (1 << 10); k++)
			cos_lut[k] = 18'(cos_slot(k));
		p_mode = 1'b0;
		p_source = 16'hFFFF;
		p_vis = 17'd65536;
		p_total = '0;
		p_peak = '0;
		p_peak_idx = '0;
		p_count = 0;
		p_error = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed raw sets: extremes, ties for the peak, a negative sample and a zero total.
		queue_sample(17'h0FFFF, 1'b0, 1'b0);
		queue_sample(17'h0FFFF, 1'b0, 1'b0);
		queue_sample(17'h00001, 1'b1, 1'b0);
		queue_sample(17'h10000, 1'b0, 1'b0);
		queue_sample(17'h08000, 1'b1, 1'b0);
		queue_sample(17'h00000, 1'b0, 1'b0);
		queue_sample(17'h00000, 1'b1, 1'b0);
		queue_sample(17'h1FFFF, 1'b1, 1'b0);
		queue_sample(17'h00400, 1'b1, 1'b0);
		drain_all();

		// Interferometer mode with full visibility: phases at the quadrant points.
		write_reg(REG_MODE, 17'd1);
		queue_sample(17'h00000, 1'b0, 1'b0);
		queue_sample(17'h04000, 1'b0, 1'b0);
		queue_sample(17'h08000, 1'b0, 1'b0);
		queue_sample(17'h1C000, 1'b0, 1'b0);
		queue_sample(17'h0FFFF, 1'b1, 1'b0);
		drain_all();
		// Visibility above one saturates; the source at zero gives zero totals.
		write_reg(REG_VIS, 17'h1FFFF);
		write_reg(REG_SOURCE, 17'd0);
		queue_sample(17'h08000, 1'b0, 1'b0);
		queue_sample(17'h00000, 1'b1, 1'b0);
		drain_all();

		// Random part in phases, each phase under different register settings.
		sent = 0;
		for (int ph = 0; sent < NUM_RANDOM; ph++) begin
			case (ph % 6)
				0: write_reg(REG_MODE, 17'd0);
				1: begin
					write_reg(REG_MODE, 17'd1);
					write_reg(REG_SOURCE, 17'hFFFF);
					write_reg(REG_VIS, 17'd65536);
				end
				2: begin
					write_reg(REG_SOURCE, 17'($urandom_range(0, 65535)));
					write_reg(REG_VIS, 17'($urandom_range(0, 131071)));
				end
				3: write_reg(REG_VIS, 17'd0);
				4: write_reg(REG_MODE, 17'd0);
				default: begin
					write_reg(REG_MODE, 17'd1);
					write_reg(REG_SOURCE, 17'($urandom_range(0, 65535)));
					write_reg(REG_VIS, 17'($urandom_range(0, 65536)));
				end
			endcase
			for (int s = 0; s < 12; s++) begin
				if ($urandom_range(0, 40) == 0)
					len = $urandom_range(257, 300);
				else
					len = $urandom_range(1, 24);
				queue_set(len, 1'b1, $urandom_range(0, 3) == 0);
				sent += len;
			end
			drain_all();
		end

		drain_all();
		$display("Covered %0d output transfers and %0d completed sets, %0d of them with status set.",
			levels_seen, sets_done, error_sets);
		$display("Both modes, saturated visibility, zero source and sets beyond the channel bound.");
		if (mismatches == 0 && expected_levels.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog on the cycle counter.
	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule

`default_nettype wire
